FILE: hw/rtl/gb3s_pkg.sv
// Package for the streaming 3x3 Gaussian blur: sizes, register indexes, types and kernel math.
`timescale 1ns / 1ps
package gb3s_pkg;

    localparam int MaxWidth   = 1024;
    localparam int ColW       = $clog2(MaxWidth);
    localparam int CfgWidthW  = 11;
    localparam int CmpW       = (ColW + 1 > CfgWidthW) ? ColW + 1 : CfgWidthW;
    localparam int PixW       = 8;
    localparam int RowW       = 16;
    localparam int CfgIdxW    = 1;
    localparam int CfgDataW   = 16;
    localparam int LineW      = 2 * PixW;
    localparam int SumW       = PixW + 4;

    localparam logic [CfgIdxW-1:0]   CfgImageWidth  = 1'b0;
    localparam logic [CfgIdxW-1:0]   CfgImageHeight = 1'b1;
    localparam logic [CfgWidthW-1:0] WidthReset     = 11'd1024;
    localparam logic [RowW-1:0]      HeightReset    = 16'd1024;

    // Window pixel k sits at row k/3, column k%3; row 0 is two rows up, column 2 is newest.
    typedef logic [8:0][PixW-1:0] t_win;

    typedef struct packed {
        logic en_a;     // centre of the middle row, previous column
        logic en_b;     // bottom row, previous column (last row only)
        logic en_c;     // middle row, last column
        logic en_d;     // bottom row, last column (frame end)
        logic top_ok;
        logic left_a;
        logic left_c;
    } t_blur_ctl;

    typedef struct packed {
        logic [PixW-1:0] pixel_out;
        logic            pixel_changed;
        logic            end_of_frame;
        logic            frame_changed;
        logic            last_of_run;
    } t_result;

    // Weighted 3x3 sum around a centre in row 1 or 2 and column 1 or 2 of the window.
    // A neighbor that is masked off or falls outside the window takes the centre value.
    function automatic logic [PixW-1:0] blur_px(
        input t_win win,
        input logic ctr_row2,
        input logic ctr_col2,
        input logic top_ok,
        input logic bot_ok,
        input logic left_ok,
        input logic right_ok
    );
        logic [SumW-1:0] sum;
        logic [PixW-1:0] ctr;
        logic [PixW-1:0] v;
        logic            ok_r;
        logic            ok_c;
        int              cr;
        int              cc;
        int              rr;
        int              kk;
        cr  = ctr_row2 ? 2 : 1;
        cc  = ctr_col2 ? 2 : 1;
        ctr = win[4'(cr * 3 + cc)];
        sum = '0;
        for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
                rr   = cr + dr - 1;
                kk   = cc + dc - 1;
                ok_r = (dr == 0) ? top_ok : ((dr == 2) ? bot_ok : 1'b1);
                ok_c = (dc == 0) ? left_ok : ((dc == 2) ? right_ok : 1'b1);
                v    = ctr;
                if (ok_r && ok_c && rr <= 2 && kk <= 2) begin
                    v = win[4'(rr * 3 + kk)];
                end
                sum = sum + (SumW'(v) << ((dr == 1 ? 1 : 0) + (dc == 1 ? 1 : 0)));
            end
        end
        return sum[SumW-1:4];
    endfunction

endpackage

FILE: hw/rtl/gb3s_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps
module gb3s_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/gaussian_blur_3x3_stream.sv
// Top level of the streaming 3x3 Gaussian blur with change detection.
//
// Usage: grey pixels of a frame enter in raster order on the input channel
// (i_in_valid / o_in_stall, payload i_pixel_value). Results leave on the output
// channel (o_out_valid / i_out_stall). A request moves when valid is high and
// stall is low. The user must set image width and height through the configuration
// channel (index 0 width, index 1 height) while no frame is in progress; it is not checked.
// Results trail the input by one row and one pixel. Inside the last row each
// pixel but the first releases two results, and the frame's last pixel four.
// The output buffer of four results must drain before the next pixel's results
// load, so every extra result holds back the input: a row's last pixel, each
// last-row pixel but the first and the frame's last pixel stall it. Otherwise
// one pixel per cycle while the receiver does not stall. The results of a
// request pass through stage 1, stage 2 and the output buffer before they show.
// Both row buffers share one line RAM read at acceptance and written back when
// the request leaves stage 1. Reset clears the pipeline, counters, window and
// change flag and loads 1024 x 1024; line RAM contents are not cleared.
// While the receiver stalls, results hold and the pipeline fills up behind
// them, then o_in_stall rises.
`timescale 1ns / 1ps
module gaussian_blur_3x3_stream (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [gb3s_pkg::PixW-1:0]      i_pixel_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [gb3s_pkg::PixW-1:0]      o_pixel_out,
    output logic                           o_pixel_changed,
    output logic                           o_end_of_frame,
    output logic                           o_frame_changed,
    output logic                           o_last_of_run,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gb3s_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [gb3s_pkg::CfgDataW-1:0]  i_cfg_data
);
    import gb3s_pkg::*;

    // Configuration registers.
    logic [CfgWidthW-1:0] r_cfg_width;
    logic [RowW-1:0]      r_cfg_height;

    // Position counters.
    logic [ColW-1:0] r_col;
    logic [RowW-1:0] r_row;
    logic [ColW-1:0] n_col;
    logic [RowW-1:0] n_row;

    // Stage 1: waiting for line RAM data.
    logic            r_s1_valid;
    logic [PixW-1:0] r_s1_pix;
    logic [ColW-1:0] r_s1_col;
    t_blur_ctl       r_s1_ctl;

    // Stage 2: window updated, blurs evaluated.
    logic      r_s2_valid;
    t_blur_ctl r_s2_ctl;
    t_win      r_win;
    t_win      n_win;
    logic      r_change_seen;
    logic      n_change_seen;

    // Output buffer of up to four results.
    t_result    r_ob [0:3];
    logic [2:0] r_ob_cnt;
    logic [1:0] r_ob_idx;

    logic [LineW-1:0] line_q;
    logic             in_acc;
    logic             ob_take;
    logic             ob_free;
    logic             s2_adv;
    logic             s2_ready;
    logic             s1_adv;
    logic             s1_ready;

    logic [CmpW-1:0]  w_raw;
    logic [CmpW-1:0]  w_use;
    logic [RowW-1:0]  h_use;
    logic             lastcol;
    logic             lastrow;
    t_blur_ctl        s0_ctl;

    t_result          cand  [0:3];
    t_result          slots [0:3];
    logic [3:0]       cand_en;
    logic [2:0]       slot_n;
    logic             cs_run;

    // Handshake control.
    assign ob_take    = (r_ob_cnt != 3'd0) && !i_out_stall;
    assign ob_free    = (r_ob_cnt == 3'd0) || ((r_ob_cnt == 3'd1) && ob_take);
    assign s2_adv     = r_s2_valid && ob_free;
    assign s2_ready   = !r_s2_valid || s2_adv;
    assign s1_adv     = r_s1_valid && s2_ready;
    assign s1_ready   = !r_s1_valid || s1_adv;
    assign o_in_stall = !s1_ready;
    assign in_acc     = i_in_valid && s1_ready;
    assign o_cfg_ready = 1'b1;

    // Position decode at acceptance.
    always_comb begin
        w_raw = CmpW'(r_cfg_width);
        if (w_raw < CmpW'(2)) begin
            w_use = CmpW'(2);
        end else if (w_raw > CmpW'(MaxWidth)) begin
            w_use = CmpW'(MaxWidth);
        end else begin
            w_use = w_raw;
        end
        h_use   = (r_cfg_height < RowW'(2)) ? RowW'(2) : r_cfg_height;
        lastcol = CmpW'(r_col) >= (w_use - CmpW'(1));
        lastrow = r_row >= (h_use - RowW'(1));

        s0_ctl.en_a   = (r_row != '0) && (r_col != '0);
        s0_ctl.en_b   = (r_row != '0) && (r_col != '0) && lastrow;
        s0_ctl.en_c   = (r_row != '0) && lastcol;
        s0_ctl.en_d   = (r_row != '0) && lastcol && lastrow;
        s0_ctl.top_ok = r_row >= RowW'(2);
        s0_ctl.left_a = r_col >= ColW'(2);
        s0_ctl.left_c = r_col != '0;

        n_col = r_col;
        n_row = r_row;
        if (lastcol) begin
            n_col = '0;
            n_row = lastrow ? '0 : r_row + RowW'(1);
        end else begin
            n_col = r_col + ColW'(1);
        end
    end

    // Line RAM: upper byte is two rows up, lower byte is the row above.
    gb3s_ram #(
        .WIDTH (LineW),
        .DEPTH (MaxWidth)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata ({line_q[PixW-1:0], r_s1_pix}),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (line_q)
    );

    // Window shift as the stage 1 item moves on.
    always_comb begin
        n_win = r_win;
        for (int k = 0; k < 3; k++) begin
            n_win[4'(k * 3)]     = r_win[4'(k * 3 + 1)];
            n_win[4'(k * 3 + 1)] = r_win[4'(k * 3 + 2)];
        end
        n_win[2] = line_q[LineW-1:PixW];
        n_win[5] = line_q[PixW-1:0];
        n_win[8] = r_s1_pix;
    end

    // Blur candidates in output order, then packed into buffer slots.
    always_comb begin
        cand[0] = '0;
        cand[1] = '0;
        cand[2] = '0;
        cand[3] = '0;
        cand[0].pixel_out = blur_px(r_win, 1'b0, 1'b0, r_s2_ctl.top_ok, 1'b1,
                                    r_s2_ctl.left_a, 1'b1);
        cand[1].pixel_out = blur_px(r_win, 1'b1, 1'b0, 1'b1, 1'b0,
                                    r_s2_ctl.left_a, 1'b1);
        cand[2].pixel_out = blur_px(r_win, 1'b0, 1'b1, r_s2_ctl.top_ok, 1'b1,
                                    r_s2_ctl.left_c, 1'b0);
        cand[3].pixel_out = blur_px(r_win, 1'b1, 1'b1, 1'b1, 1'b0,
                                    r_s2_ctl.left_c, 1'b0);
        cand[0].pixel_changed = cand[0].pixel_out != r_win[4];
        cand[1].pixel_changed = cand[1].pixel_out != r_win[7];
        cand[2].pixel_changed = cand[2].pixel_out != r_win[5];
        cand[3].pixel_changed = cand[3].pixel_out != r_win[8];
        cand[3].end_of_frame  = 1'b1;
        cand_en = {r_s2_ctl.en_d, r_s2_ctl.en_c, r_s2_ctl.en_b, r_s2_ctl.en_a};

        slots[0] = '0;
        slots[1] = '0;
        slots[2] = '0;
        slots[3] = '0;
        slot_n   = 3'd0;
        cs_run   = r_change_seen;
        for (int i = 0; i < 4; i++) begin
            if (cand_en[i]) begin
                cs_run = cs_run || cand[i].pixel_changed;
                if (cand[i].end_of_frame) begin
                    cand[i].frame_changed = cs_run;
                    cs_run = 1'b0;
                end
                slots[slot_n[1:0]] = cand[i];
                slot_n = slot_n + 3'd1;
            end
        end
        if (slot_n != 3'd0) begin
            slots[2'(slot_n - 3'd1)].last_of_run = 1'b1;
        end
        n_change_seen = cs_run;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= WidthReset;
            r_cfg_height  <= HeightReset;
            r_col         <= '0;
            r_row         <= '0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_change_seen <= 1'b0;
            r_win         <= '0;
            r_ob_cnt      <= 3'd0;
            r_ob_idx      <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CfgImageWidth:  r_cfg_width  <= i_cfg_data[CfgWidthW-1:0];
                    CfgImageHeight: r_cfg_height <= i_cfg_data[RowW-1:0];
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (s1_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (s1_adv) begin
                r_win <= n_win;
            end
            if (s2_adv) begin
                r_change_seen <= n_change_seen;
                r_ob_cnt      <= slot_n;
                r_ob_idx      <= 2'd0;
            end else if (ob_take) begin
                r_ob_cnt <= r_ob_cnt - 3'd1;
                r_ob_idx <= r_ob_idx + 2'd1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_pixel_value;
            r_s1_col <= r_col;
            r_s1_ctl <= s0_ctl;
        end
        if (s1_adv) begin
            r_s2_ctl <= r_s1_ctl;
        end
        if (s2_adv) begin
            for (int i = 0; i < 4; i++) begin
                r_ob[i] <= slots[i];
            end
        end
    end

    assign o_out_valid     = r_ob_cnt != 3'd0;
    assign o_pixel_out     = r_ob[r_ob_idx].pixel_out;
    assign o_pixel_changed = r_ob[r_ob_idx].pixel_changed;
    assign o_end_of_frame  = r_ob[r_ob_idx].end_of_frame;
    assign o_frame_changed = r_ob[r_ob_idx].frame_changed;
    assign o_last_of_run   = r_ob[r_ob_idx].last_of_run;

`ifndef SYNTHESIS
    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt <= 3'd4)
        else $error("output buffer count above four");

    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_of_frame) |-> o_last_of_run)
        else $error("frame end result is not the last of its run");

    a_fc_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_changed) |-> o_end_of_frame)
        else $error("frame change flag outside the frame end result");

    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted pixel did not reach stage one");
`endif

endmodule
